// ===== rtl/core/isort_pkg.sv =====
// Shared types and constants for the insertion sorter.
// Depends on nothing; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package isort_pkg;

   // Width of one sorted value
   localparam int unsigned DATA_W = 32;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;     // take a new request, start scanning from the fill count
      logic drop;     // store full: flag that a value was lost
      logic shift;    // move the read entry up one place, step down
      logic place;    // write the new value at the current position
      logic emit_rd;  // read the next entry for output
      logic clear;    // end of set: empty the store, clear the overflow flag
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic full;       // fill count at capacity
      logic count_zero; // store empty
      logic less;       // new value sorts before the entry just read
      logic pos_one;    // insert position is one
      logic last;       // held request closes the set
      logic emit_last;  // output read pointer on the final entry
   } sts_type;

endpackage

// ===== rtl/core/insertion_sorter.sv =====
// Stable ascending insertion sorter for signed 32-bit values.
// Insert: each stored value greater than the new one moves up one place, one RAM shift per
// cycle, and the new value is written into the gap; a full store drops the value instead.
// A closing request then emits all stored results in ascending order on consecutive cycles,
// after which the store is emptied and the block is ready again.
// Synchronous reset empties the store and clears overflow; results cannot be stalled.
`timescale 1ns / 1ps

module insertion_sorter #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [isort_pkg::DATA_W-1:0] req_sample_value,
   input  logic                                req_set_end,
   output logic                                rsp_strobe,
   output logic signed [isort_pkg::DATA_W-1:0] rsp_sorted_value,
   output logic                                rsp_run_end,
   output logic                                rsp_overflow
);

   isort_pkg::cmd_type cmd;
   isort_pkg::sts_type sts;

   // Sequencer
   isort_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_set_end (req_set_end),
      .sts         (sts),
      .cmd         (cmd),
      .busy        (busy)
   );

   // Store and result path
   isort_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_sample_value (req_sample_value),
      .req_set_end      (req_set_end),
      .rsp_strobe       (rsp_strobe),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_run_end      (rsp_run_end),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

// ===== rtl/core/isort_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module isort_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/isort_datapath.sv =====
// Datapath of the insertion sorter: sorted store, fill count, insert position,
// output pointer and result registers. Depends on isort_pkg and isort_ram.
`timescale 1ns / 1ps

module isort_datapath #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  isort_pkg::cmd_type                  cmd,
   output isort_pkg::sts_type                  sts,
   input  logic signed [isort_pkg::DATA_W-1:0] req_sample_value,
   input  logic                                req_set_end,
   output logic                                rsp_strobe,
   output logic signed [isort_pkg::DATA_W-1:0] rsp_sorted_value,
   output logic                                rsp_run_end,
   output logic                                rsp_overflow
);

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          dropped_ff, dropped_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] rdptr_ff, rdptr_in;
   logic          strobe_ff, run_end_ff;
   logic signed [isort_pkg::DATA_W-1:0] value_ff, value_in;
   logic          last_ff, last_in;

   logic          wr_en;
   logic [AW-1:0] rd_addr;
   logic [isort_pkg::DATA_W-1:0] wr_data;
   logic [isort_pkg::DATA_W-1:0] rd_data;

   // Store
   isort_ram #(
      .WIDTH (isort_pkg::DATA_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Store write and read address selection
   always_comb begin
      wr_en   = cmd.shift | cmd.place;
      wr_data = cmd.shift ? rd_data : value_ff;
      if (cmd.emit_rd) begin
         rd_addr = rdptr_ff;
      end else if (cmd.load) begin
         rd_addr = AW'(count_ff - CW'(1));
      end else begin
         rd_addr = pos_ff - AW'(2);
      end
   end

   // Next state of the registers
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      pos_in     = pos_ff;
      rdptr_in   = rdptr_ff;
      value_in   = value_ff;
      last_in    = last_ff;
      if (cmd.load) begin
         value_in = req_sample_value;
         last_in  = req_set_end;
         pos_in   = AW'(count_ff);
      end
      if (cmd.drop) begin
         dropped_in = 1'b1;
      end
      if (cmd.shift) begin
         pos_in = pos_ff - AW'(1);
      end
      if (cmd.place) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.emit_rd) begin
         rdptr_in = sts.emit_last ? '0 : rdptr_ff + AW'(1);
      end
      if (cmd.clear) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         rdptr_ff   <= '0;
         strobe_ff  <= 1'b0;
         run_end_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         rdptr_ff   <= rdptr_in;
         strobe_ff  <= cmd.emit_rd;
         run_end_ff <= cmd.emit_rd & sts.emit_last;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   // Status
   always_comb begin
      sts.full       = (count_ff >= CW'(CAPACITY));
      sts.count_zero = (count_ff == '0);
      sts.less       = (value_ff < $signed(rd_data));
      sts.pos_one    = (pos_ff == AW'(1));
      sts.last       = last_ff;
      sts.emit_last  = (CW'(rdptr_ff) == count_ff - CW'(1));
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_sorted_value = $signed(rd_data);
   assign rsp_run_end      = run_end_ff;
   assign rsp_overflow     = dropped_ff;

endmodule

// ===== rtl/core/isort_ctrl.sv =====
// Controller of the insertion sorter: sequences insert, shift and output steps.
// Depends on isort_pkg.
`timescale 1ns / 1ps

module isort_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_set_end,
   input  isort_pkg::sts_type sts,
   output isort_pkg::cmd_type cmd,
   output logic               busy
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_PLACE = 3'd2;
   localparam logic [2:0] ST_EMIT  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (sts.full) begin
                  // value lost; a closing request still flushes the set
                  cmd.drop = 1'b1;
                  if (req_set_end) begin
                     state_in = ST_EMIT;
                  end
               end else begin
                  cmd.load = 1'b1;
                  state_in = sts.count_zero ? ST_PLACE : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // compare against the entry read last cycle
            if (sts.less) begin
               cmd.shift = 1'b1;
               if (sts.pos_one) begin
                  state_in = ST_PLACE;
               end
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
            state_in  = sts.last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            cmd.emit_rd = 1'b1;
            if (sts.emit_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // final result is out this cycle
            cmd.clear = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
